// ===== rtl/core/ict_pkg.sv =====
// ---------------------------------------------------------------------------
// ict_pkg : shared types and constants for the interval coverage table
// Opcodes, status codes, sequencer states and default sizes.
// ---------------------------------------------------------------------------
package ict_pkg;

   localparam int DefMaxSegments = 256;
   localparam int DefHistTop     = 64;
   localparam logic [6:0] MaxCovReset = 7'd64;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_QUERY = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_BADIX = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN,
      S_EMIT,
      S_COPY_RD,
      S_COPY,
      S_Q_RD,
      S_Q_MUL,
      S_Q_ACC,
      S_HIST,
      S_CLEAR,
      S_DONE
   } state_type;

endpackage

// ===== rtl/core/ict_if.sv =====
// ---------------------------------------------------------------------------
// ict_req_if / ict_rsp_if : request and response channels
// Valid/ready handshake channels carrying one item each.
// ---------------------------------------------------------------------------
interface ict_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] range_begin;
   logic [31:0] range_end;
   logic [15:0] add_weight;
   logic [6:0]  bin_index;
   modport source (output valid, opcode, range_begin, range_end, add_weight, bin_index,
                   input ready);
   modport sink   (input valid, opcode, range_begin, range_end, add_weight, bin_index,
                   output ready);
endinterface

interface ict_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [8:0]  new_segments;
   logic [31:0] covered_length;
   logic [63:0] weighted_sum;
   logic [47:0] bin_value;
   modport source (output valid, status, new_segments, covered_length, weighted_sum,
                   bin_value, input ready);
   modport sink   (input valid, status, new_segments, covered_length, weighted_sum,
                   bin_value, output ready);
endinterface

// ===== rtl/core/interval_coverage_table_top.sv =====
// ---------------------------------------------------------------------------
// interval_coverage_table_top : sorted segment table with coverage histogram
// Keeps disjoint segments sorted by stop, merges weighted ranges into them,
// answers coverage queries and keeps a length histogram by coverage.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  req      | in  | req.valid/ready   | opcode, range_begin, range_end, weight, bin
//  rsp      | out | rsp.valid/ready   | status, new_segments, lengths, sum, bin
//  csr      | in  | csr_wr_en         | max_cov (7 bits)
//
// Steps: every item has its accept step and one done step, with the work
//   between. An add walks the segments ahead of the range, emits pieces for
//   each overlapped segment, passes on those behind it, then copies the work
//   table back; a query reads each segment walked and accumulates each one
//   it overlaps; a bin read has no work steps; a clear sweeps every bin.
// Work is bounded by the one segment memory read port and one multiplier.
// Reset clears control, segment count and histogram (a sweep of all
//   HistTop+2 bins with ready low, and no result for it).
// The response register holds a finished item until rsp.ready; req.ready
// is high whenever the sequencer is idle, and a finished item holds in the
// done step until the response register frees.
// ---------------------------------------------------------------------------
module interval_coverage_table_top #(
   parameter int MaxSegments = ict_pkg::DefMaxSegments,
   parameter int HistTop     = ict_pkg::DefHistTop
) (
   input  logic        clock,
   input  logic        reset,
   ict_req_if.sink     req,
   ict_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import ict_pkg::*;

   localparam int AW = $clog2(MaxSegments);
   localparam int CW = $clog2(MaxSegments + 1);
   localparam int NBins = HistTop + 2;
   localparam int BW = $clog2(NBins);
   localparam int MW = (BW > 7) ? BW : 7;
   localparam logic [47:0] BinMax = {48{1'b1}};

   // segment memory (current) and work memory (add result)
   logic [95:0] seg_mem [MaxSegments];
   logic [95:0] wrk_mem [MaxSegments];
   logic [47:0] hist_mem [NBins];

   state_type   state_ff, state_in;
   logic        init_ff;    // histogram sweep after reset in progress
   logic [6:0]  max_cov_ff;
   logic [CW-1:0] seg_count_ff, idx_ff, wcnt_ff;
   logic        over_ff;
   logic [1:0]  op_ff;
   logic [31:0] b_ff, e_ff, w_ff;
   logic [6:0]  bix_ff;
   logic [31:0] s_ff, t_ff, c_ff;
   logic [95:0] rd_ff, wrd_ff;
   logic [8:0]  created_ff;
   logic [1:0]  phase_ff;   // emit sub-step within one overlapped segment
   logic [31:0] len_ff, o_ff;
   logic [63:0] sum_ff, prod_ff;
   logic [BW-1:0] bin_ff, clr_ff;
   logic [47:0] hrd_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [8:0]  rsp_new_ff;
   logic [31:0] rsp_len_ff;
   logic [63:0] rsp_sum_ff;
   logic [47:0] rsp_bin_ff;

   logic [MW-1:0] mc;
   assign mc = (MW'(max_cov_ff) > MW'(HistTop)) ? MW'(HistTop) : MW'(max_cov_ff);

   function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] r;
      r = {1'b0, a} + {1'b0, b};
      return r[32] ? 32'hFFFF_FFFF : r[31:0];
   endfunction

   assign req.ready = (state_ff == S_IDLE);
   wire accept = req.valid && req.ready;
   wire rsp_free = !rsp_valid_ff || rsp.ready;
   wire in_rng = idx_ff < seg_count_ff;

   // one emit decision per cycle in S_EMIT
   logic        em_valid, em_adv, em_done;
   logic [95:0] em_data;
   logic        em_new;
   logic [31:0] b_next;
   logic [1:0]  ph_next;

   always_comb begin
      em_valid = 1'b0; em_adv = 1'b0; em_done = 1'b0; em_new = 1'b0;
      em_data = '0; b_next = b_ff; ph_next = phase_ff;
      if (phase_ff == 2'd0 && (!in_rng || !(b_ff < e_ff))) begin
         // tail: leftover gap then copy remaining entries
         if (b_ff < e_ff) begin
            em_valid = 1'b1; em_new = 1'b1; em_data = {b_ff, e_ff, w_ff}; b_next = e_ff;
         end else if (in_rng) begin
            em_valid = 1'b1; em_data = {s_ff, t_ff, c_ff}; em_adv = 1'b1;
         end else begin
            em_done = 1'b1;
         end
      end else if (phase_ff == 2'd0) begin
         if (b_ff < s_ff) begin
            em_valid = 1'b1; em_new = 1'b1;
            b_next = (s_ff < e_ff) ? s_ff : e_ff;
            em_data = {b_ff, b_next, w_ff};
         end
         ph_next = 2'd1;
         if (!(e_ff > s_ff) && !(b_ff < s_ff)) begin
            em_valid = 1'b1; em_data = {s_ff, t_ff, c_ff}; em_adv = 1'b1; ph_next = 2'd0;
         end else if (!(e_ff > s_ff)) begin
            ph_next = 2'd3;   // gap emitted; segment itself next
         end
      end else if (phase_ff == 2'd3) begin
         em_valid = 1'b1; em_data = {s_ff, t_ff, c_ff}; em_adv = 1'b1; ph_next = 2'd0;
      end else if (phase_ff == 2'd1) begin
         if (b_ff > s_ff) begin
            em_valid = 1'b1; em_new = 1'b1; em_data = {s_ff, b_ff, c_ff};
         end
         ph_next = 2'd2;
      end else begin
         if (e_ff < t_ff) begin
            if (b_ff != e_ff) begin
               em_valid = 1'b1; em_new = 1'b1; em_data = {b_ff, e_ff, sat32(c_ff, w_ff)};
               b_next = e_ff;
            end else begin
               em_valid = 1'b1; em_data = {e_ff, t_ff, c_ff};
               b_next = t_ff; em_adv = 1'b1; ph_next = 2'd0;
            end
         end else begin
            em_valid = 1'b1; em_data = {b_ff, t_ff, sat32(c_ff, w_ff)};
            b_next = t_ff; em_adv = 1'b1; ph_next = 2'd0;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            case (opcode_type'(req.opcode))
               OP_ADD:   state_in = (req.range_begin >= req.range_end) ? S_DONE : S_SCAN_RD;
               OP_QUERY: state_in = (req.range_begin >= req.range_end) ? S_DONE : S_Q_RD;
               OP_READ:  state_in = S_DONE;
               default:  state_in = S_CLEAR;
            endcase
         end
         S_SCAN_RD: state_in = S_SCAN;
         S_SCAN: begin
            if (in_rng && t_ff <= b_ff) state_in = S_SCAN_RD;
            else state_in = S_EMIT;
         end
         S_EMIT: begin
            if (em_done) state_in = over_ff ? S_DONE : S_COPY_RD;
            else if (em_adv) state_in = S_SCAN_RD;
         end
         S_COPY_RD: state_in = (idx_ff < wcnt_ff) ? S_COPY : S_DONE;
         S_COPY:    state_in = S_COPY_RD;
         S_Q_RD:    state_in = in_rng ? S_Q_MUL : S_DONE;
         S_Q_MUL: begin
            if (t_ff <= b_ff) state_in = S_Q_RD;
            else if (s_ff >= e_ff) state_in = S_DONE;
            else state_in = S_Q_ACC;
         end
         S_Q_ACC:   state_in = S_HIST;
         S_HIST:    state_in = S_Q_RD;
         S_CLEAR: begin
            if (clr_ff != BW'(NBins - 1)) state_in = S_CLEAR;
            else state_in = init_ff ? S_IDLE : S_DONE;
         end
         S_DONE:    state_in = rsp_free ? S_IDLE : S_DONE;
         default:   state_in = S_IDLE;
      endcase
   end

   // S_SCAN_RD fetch: rd_ff holds entry idx_ff once loaded; S_SCAN_RD and S_Q_RD
   // load the segment fields.  In S_SCAN a skipped segment relatches s/t/c from rd_ff.
   logic [63:0] sum_add;
   logic [64:0] sum_wide;
   assign sum_wide = {1'b0, sum_ff} + {1'b0, prod_ff};
   assign sum_add  = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
   logic [48:0] hist_wide;
   assign hist_wide = {1'b0, hrd_ff} + {17'b0, o_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         init_ff <= 1'b1;
         max_cov_ff <= MaxCovReset;
         seg_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         clr_ff <= '0;
         op_ff <= OP_CLEAR;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) max_cov_ff <= csr_wr_data;
         if (state_ff == S_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (accept) begin
               op_ff <= req.opcode; b_ff <= req.range_begin; e_ff <= req.range_end;
               w_ff <= {16'b0, req.add_weight}; bix_ff <= req.bin_index;
               idx_ff <= '0; wcnt_ff <= '0; over_ff <= 1'b0; created_ff <= '0;
               phase_ff <= 2'd0; len_ff <= '0; sum_ff <= '0; clr_ff <= '0;
               if (req.bin_index <= 7'(mc) + 7'd1 && BW'(req.bin_index) < BW'(NBins))
                  hrd_ff <= hist_mem[BW'(req.bin_index)];
               else hrd_ff <= '0;
            end
            S_SCAN_RD, S_Q_RD: begin
               rd_ff <= seg_mem[AW'(idx_ff)];
            end
            S_SCAN: begin
               if (in_rng && t_ff <= b_ff) begin
                  if (wcnt_ff >= CW'(MaxSegments)) over_ff <= 1'b1;
                  else begin
                     wrk_mem[AW'(wcnt_ff)] <= {s_ff, t_ff, c_ff};
                     wcnt_ff <= wcnt_ff + 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_EMIT: begin
               if (em_valid) begin
                  if (wcnt_ff >= CW'(MaxSegments)) over_ff <= 1'b1;
                  else begin
                     wrk_mem[AW'(wcnt_ff)] <= em_data;
                     wcnt_ff <= wcnt_ff + 1'b1;
                  end
               end
               if (em_new) created_ff <= created_ff + 9'd1;
               b_ff <= b_next; phase_ff <= ph_next;
               if (em_adv) idx_ff <= idx_ff + 1'b1;
               if (em_done) idx_ff <= '0;
            end
            S_COPY_RD: wrd_ff <= wrk_mem[AW'(idx_ff)];
            S_COPY: begin
               seg_mem[AW'(idx_ff)] <= wrd_ff;
               idx_ff <= idx_ff + 1'b1;
            end
            S_Q_MUL: begin
               o_ff <= ((t_ff < e_ff) ? t_ff : e_ff) - ((s_ff > b_ff) ? s_ff : b_ff);
               bin_ff <= (MW'(c_ff[6:0]) > mc || c_ff[31:7] != '0) ?
                         BW'(mc + 1'b1) : BW'(c_ff[6:0]);
               idx_ff <= idx_ff + 1'b1;
            end
            S_Q_ACC: begin
               prod_ff <= {32'b0, o_ff} * {32'b0, c_ff};
               len_ff <= len_ff + o_ff;
               hrd_ff <= hist_mem[bin_ff];
            end
            S_HIST: begin
               sum_ff <= sum_add;
               hist_mem[bin_ff] <= (hist_wide > {1'b0, BinMax}) ? BinMax : hist_wide[47:0];
            end
            S_CLEAR: begin
               hist_mem[clr_ff] <= '0;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == BW'(NBins - 1)) init_ff <= 1'b0;
            end
            S_DONE: if (rsp_free) begin
               rsp_status_ff <= ST_OK; rsp_new_ff <= '0; rsp_len_ff <= '0;
               rsp_sum_ff <= '0; rsp_bin_ff <= '0;
               case (opcode_type'(op_ff))
                  OP_ADD, OP_QUERY: begin
                     if (b_ff >= e_ff && wcnt_ff == '0 && created_ff == '0 &&
                         len_ff == '0 && idx_ff == '0) rsp_status_ff <= ST_EMPTY;
                     else if (op_ff == OP_ADD) begin
                        if (over_ff) rsp_status_ff <= ST_FULL;
                        else begin
                           rsp_new_ff <= created_ff;
                           seg_count_ff <= wcnt_ff;
                        end
                     end else begin
                        rsp_len_ff <= len_ff; rsp_sum_ff <= sum_ff;
                     end
                  end
                  OP_READ: begin
                     if (bix_ff > 7'(mc) + 7'd1) rsp_status_ff <= ST_BADIX;
                     else rsp_bin_ff <= hrd_ff;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // segment field view of the fetched entry
   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN_RD || state_ff == S_Q_RD) begin
         s_ff <= seg_mem[AW'(idx_ff)][95:64];
         t_ff <= seg_mem[AW'(idx_ff)][63:32];
         c_ff <= seg_mem[AW'(idx_ff)][31:0];
      end else if (state_ff == S_SCAN && in_rng && t_ff <= b_ff) begin
         s_ff <= rd_ff[95:64]; t_ff <= rd_ff[63:32]; c_ff <= rd_ff[31:0];
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.new_segments   = rsp_new_ff;
   assign rsp.covered_length = rsp_len_ff;
   assign rsp.weighted_sum   = rsp_sum_ff;
   assign rsp.bin_value      = rsp_bin_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE) else $error("stray result");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      seg_count_ff <= CW'(MaxSegments)) else $error("segment count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_status_ff) &&
      $stable(rsp_len_ff) && $stable(rsp_sum_ff) && $stable(rsp_bin_ff))
      else $error("result changed while held");
endmodule

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench : self-checking bench for the interval coverage table
// Drives adds, queries, bin reads and clears through the request channel,
// predicts each response with a local model of the segment table and the
// histogram, and compares every response field by field, in order.
// ---------------------------------------------------------------------------
module testbench;
   import ict_pkg::*;

   localparam int NumSegments = DefMaxSegments;
   localparam int NumBins     = DefHistTop + 2;
   localparam longint unsigned BinCap = 48'hFFFF_FFFF_FFFF;
   localparam int CycleLimit  = 20000000;

   typedef struct packed {
      status_type  status;
      logic [8:0]  new_segments;
      logic [31:0] covered_length;
      logic [63:0] weighted_sum;
      logic [47:0] bin_value;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [6:0] csr_wr_data = '0;

   ict_req_if req ();
   ict_rsp_if rsp ();

   interval_coverage_table_top uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // Predicted table and histogram.
   logic [31:0] seg_lo [NumSegments];
   logic [31:0] seg_hi [NumSegments];
   logic [31:0] seg_cov [NumSegments];
   int          seg_total;
   logic [47:0] cov_hist [NumBins];
   logic [6:0]  max_cov_reg;

   response_type pending_responses[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;   // chance in 100 that the sender stays idle at each check
   int  recv_stall_pct = 0;  // chance in 100 that the receiver stalls at each check
   int  hold_off_cycles = 0; // long receiver hold-off, counted down below

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   function automatic int effective_max();
      return (max_cov_reg > DefHistTop) ? DefHistTop : int'(max_cov_reg);
   endfunction

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // Merge a weighted range into the table; returns created count or -1 if full.
   function automatic int merge_range(input logic [31:0] b, input logic [31:0] e,
                                      input logic [31:0] w);
      logic [31:0] nlo [NumSegments];
      logic [31:0] nhi [NumSegments];
      logic [31:0] ncov [NumSegments];
      logic [31:0] s, t, c, g;
      int n, i, made;
      bit over;
      n = 0; i = 0; made = 0; over = 0;
      while (i < seg_total && seg_hi[i] <= b) begin
         if (n >= NumSegments) over = 1;
         else begin nlo[n] = seg_lo[i]; nhi[n] = seg_hi[i]; ncov[n] = seg_cov[i]; n++; end
         i++;
      end
      for (; i < seg_total && b < e; i++) begin
         s = seg_lo[i]; t = seg_hi[i]; c = seg_cov[i];
         if (b < s) begin
            g = (s < e) ? s : e;
            if (n >= NumSegments) over = 1;
            else begin nlo[n] = b; nhi[n] = g; ncov[n] = w; n++; end
            made++;
            b = g;
         end
         if (e > s) begin
            if (b > s) begin
               if (n >= NumSegments) over = 1;
               else begin nlo[n] = s; nhi[n] = b; ncov[n] = c; n++; end
               made++;
            end
            if (e < t) begin
               if (n >= NumSegments) over = 1;
               else begin nlo[n] = b; nhi[n] = e; ncov[n] = sat_add32(c, w); n++; end
               made++;
               if (n >= NumSegments) over = 1;
               else begin nlo[n] = e; nhi[n] = t; ncov[n] = c; n++; end
            end else begin
               if (n >= NumSegments) over = 1;
               else begin nlo[n] = b; nhi[n] = t; ncov[n] = sat_add32(c, w); n++; end
            end
            b = t;
         end else begin
            if (n >= NumSegments) over = 1;
            else begin nlo[n] = s; nhi[n] = t; ncov[n] = c; n++; end
         end
      end
      if (b < e) begin
         if (n >= NumSegments) over = 1;
         else begin nlo[n] = b; nhi[n] = e; ncov[n] = w; n++; end
         made++;
      end
      for (; i < seg_total; i++) begin
         if (n >= NumSegments) over = 1;
         else begin nlo[n] = seg_lo[i]; nhi[n] = seg_hi[i]; ncov[n] = seg_cov[i]; n++; end
      end
      if (over) return -1;
      for (int k = 0; k < n; k++) begin
         seg_lo[k] = nlo[k]; seg_hi[k] = nhi[k]; seg_cov[k] = ncov[k];
      end
      seg_total = n;
      return made;
   endfunction

   function automatic response_type predict_response(input opcode_type op,
         input logic [31:0] b, input logic [31:0] e, input logic [15:0] w,
         input logic [6:0] idx);
      response_type r;
      logic [31:0] lo, hi, o, len;
      logic [63:0] sum, p;
      logic [48:0] acc;
      int mc, bin, made;
      r = '0;
      r.status = ST_OK;
      mc = effective_max();
      case (op)
         OP_ADD, OP_QUERY: begin
            if (b >= e) r.status = ST_EMPTY;
            else if (op == OP_ADD) begin
               made = merge_range(b, e, {16'd0, w});
               if (made < 0) r.status = ST_FULL;
               else r.new_segments = made[8:0];
            end else begin
               len = 0; sum = 0;
               for (int i = 0; i < seg_total; i++) begin
                  if (seg_hi[i] <= b) continue;
                  if (seg_lo[i] >= e) break;
                  lo = (seg_lo[i] > b) ? seg_lo[i] : b;
                  hi = (seg_hi[i] < e) ? seg_hi[i] : e;
                  o = hi - lo;
                  len += o;
                  p = 64'(o) * 64'(seg_cov[i]);
                  sum = (sum + p < sum) ? 64'hFFFF_FFFF_FFFF_FFFF : sum + p;
                  bin = (seg_cov[i] > 32'(mc)) ? mc + 1 : int'(seg_cov[i]);
                  acc = {1'b0, cov_hist[bin]} + 49'(o);
                  cov_hist[bin] = (acc > 49'(BinCap)) ? BinCap[47:0] : acc[47:0];
               end
               r.covered_length = len;
               r.weighted_sum = sum;
            end
         end
         OP_READ: begin
            if (int'(idx) > mc + 1) r.status = ST_BADIX;
            else r.bin_value = cov_hist[idx];
         end
         default: foreach (cov_hist[k]) cov_hist[k] = '0;
      endcase
      return r;
   endfunction

   // Response checker: sample at the rising edge, drive ready at the falling one.
   always @(posedge clock) begin
      response_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response", rsp.status, 0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp.status !== want.status)
               report_mismatch("status", rsp.status, want.status);
            if (rsp.new_segments !== want.new_segments)
               report_mismatch("new_segments", rsp.new_segments, want.new_segments);
            if (rsp.covered_length !== want.covered_length)
               report_mismatch("covered_length", rsp.covered_length, want.covered_length);
            if (rsp.weighted_sum !== want.weighted_sum)
               report_mismatch("weighted_sum", rsp.weighted_sum, want.weighted_sum);
            if (rsp.bin_value !== want.bin_value)
               report_mismatch("bin_value", rsp.bin_value, want.bin_value);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("timeout");
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Send one item: random idle gaps first, then hold until accepted.
   task automatic send_item(input opcode_type op, input logic [31:0] b,
                            input logic [31:0] e, input logic [15:0] w,
                            input logic [6:0] idx);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req.valid = 1'b1;
      req.opcode <= op;
      req.range_begin <= b;
      req.range_end <= e;
      req.add_weight <= w;
      req.bin_index <= idx;
      do @(posedge clock); while (!req.ready);
      pending_responses.push_back(predict_response(op, b, e, w, idx));
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   // Drain outstanding responses, then let a cleared histogram sweep finish.
   task automatic wait_idle();
      while (pending_responses.size() != 0) @(negedge clock);
      repeat (DefHistTop + 8) @(negedge clock);
   endtask

   task automatic write_max_cov(input logic [6:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      max_cov_reg = value;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Random item. Positions stay in a small window most of the time so ranges
   // overlap and split often; a few are drawn from the whole address space.
   task automatic send_random_item();
      logic [31:0] b, e;
      logic [15:0] w;
      int pick;
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0) begin
         b = $urandom; e = $urandom;
      end else begin
         b = $urandom_range(400); e = b + $urandom_range(60);
         if ($urandom_range(9) == 0) e = b - $urandom_range(3);
      end
      w = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(5));
      // The table is not emptied during the run: reset is not reasserted, so once it
      // fills, adds are rejected as full while queries still go on.
      if (pick < 45) send_item(OP_ADD, b, e, w, 7'($urandom));
      else if (pick < 80) send_item(OP_QUERY, b, e, w, 7'($urandom));
      else if (pick < 97) send_item(OP_READ, b, e, w, 7'($urandom_range(70)));
      else send_item(OP_CLEAR, b, e, w, 7'($urandom));
   endtask

   task automatic test_directed();
      send_item(OP_QUERY, 32'd0, 32'd100, 16'd0, 7'd0);          // empty table
      send_item(OP_ADD, 32'd10, 32'd10, 16'd1, 7'd0);            // empty range
      send_item(OP_QUERY, 32'd20, 32'd5, 16'd0, 7'd0);           // inverted range
      send_item(OP_ADD, 32'd100, 32'd200, 16'd3, 7'd0);
      send_item(OP_ADD, 32'd50, 32'd150, 16'd2, 7'd0);           // split and gap
      send_item(OP_ADD, 32'd120, 32'd130, 16'hFFFF, 7'd0);       // inner split
      send_item(OP_ADD, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 7'd0);   // covers everything
      send_item(OP_QUERY, 32'd0, 32'hFFFF_FFFF, 16'd0, 7'd0);
      send_item(OP_READ, 32'd0, 32'd0, 16'd0, 7'd65);            // overflow bin when max_cov is 64
      send_item(OP_READ, 32'd0, 32'd0, 16'd0, 7'd66);            // bad index
      send_item(OP_READ, 32'd0, 32'd0, 16'd0, 7'h7F);
      send_item(OP_READ, 32'd0, 32'd0, 16'd0, 7'd0);
      send_item(OP_CLEAR, 32'd0, 32'd0, 16'd0, 7'd0);
      send_item(OP_READ, 32'd0, 32'd0, 16'd0, 7'd65);
   endtask

   // Repeated max-weight adds deepen one range's stored depth; queries and an overflow-bin read follow.
   task automatic test_saturation();
      for (int i = 0; i < 6; i++)
         send_item(OP_ADD, 32'hFFFF_FF00, 32'hFFFF_FFFF, 16'hFFFF, 7'd0);
      repeat (3) send_item(OP_QUERY, 32'd0, 32'hFFFF_FFFF, 16'd0, 7'd0);
      send_item(OP_READ, 32'd0, 32'd0, 16'd0, 7'd65);
   endtask

   // Fill the table with single-point segments until adds are rejected.
   task automatic test_table_full();
      for (int i = 0; i < 140; i++)
         send_item(OP_ADD, 32'(1000 + 3 * i), 32'(1001 + 3 * i), 16'd1, 7'd0);
      send_item(OP_ADD, 32'd990, 32'd1500, 16'd1, 7'd0);        // creates too many
      send_item(OP_QUERY, 32'd900, 32'd1600, 16'd0, 7'd0);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_random_item();
   endtask

   // Hold the receiver off while the sender keeps offering items.
   task automatic test_backpressure();
      set_idling(0, 0);
      hold_off_cycles = 3000;
      test_random(20);
      // Pause until every result has come, then resume.
      while (pending_responses.size() != 0) @(negedge clock);
      test_random(20);
   endtask

   initial begin
      req.valid = 1'b0; req.opcode = OP_ADD; req.range_begin = '0;
      req.range_end = '0; req.add_weight = '0; req.bin_index = '0;
      rsp.ready = 1'b0;
      seg_total = 0;
      foreach (cov_hist[k]) cov_hist[k] = '0;
      max_cov_reg = MaxCovReset;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_saturation();
      write_max_cov(7'd0);
      test_directed();
      write_max_cov(7'h7F);                                       // above top: acts as top
      send_item(OP_READ, 32'd0, 32'd0, 16'd0, 7'd65);
      send_item(OP_READ, 32'd0, 32'd0, 16'd0, 7'd66);
      write_max_cov(7'd3);
      test_table_full();
      test_backpressure();
      set_idling(65, 0);  test_random(300);
      write_max_cov(7'd64);
      set_idling(0, 65);  test_random(300);
      write_max_cov(7'd1);
      set_idling(12, 12); test_random(300);
      write_max_cov(7'd40);
      set_idling(0, 0);   test_random(100);
      wait_idle();
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ict_pkg.sv
rtl/core/ict_if.sv
rtl/core/interval_coverage_table_top.sv
tb/sv/testbench.sv
